/* src/dvm_pkg.sv */
// Shared types, widths and constants of the dynamic vibration magnitude block.
`timescale 1ns / 1ps

package dvm_pkg;

   localparam int SAMPLE_W                  = 16;
   localparam int WEIGHT_W                  = 16;
   localparam int OUT_FRAC_BITS             = 8;
   localparam int GRAVITY_FRACTION_BITS_DEF = 16;
   localparam int RES_W                     = SAMPLE_W + 1 + OUT_FRAC_BITS;
   localparam int SQ_W                      = 2 * RES_W - 1;
   localparam int SUM_W                     = SQ_W + 1;
   localparam int ROOT_W                    = SUM_W / 2;
   localparam int CSR_ADDR_W                = 3;
   localparam int CSR_DATA_W                = 32;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd64881;
   localparam logic REG_SMOOTHING_WEIGHT = 1'b0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [SQ_W-1:0] square_type;
   typedef logic [ROOT_W-1:0] root_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_UPDATE,
      ST_SQUARE,
      ST_MERGE,
      ST_ROOT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mac;
      logic wbit;
      logic update;
      logic primed;
      logic square;
   } lane_ctl_type;

endpackage

/* src/dvm_lane.sv */
// One axis lane: gravity estimate, bit-serial filter multiply, residual and its square.
`timescale 1ns / 1ps

module dvm_lane #(
   parameter int GRAVITY_FRACTION_BITS = dvm_pkg::GRAVITY_FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dvm_pkg::lane_ctl_type ctl,
   input  dvm_pkg::sample_type  sample,
   output dvm_pkg::square_type  square
);
   import dvm_pkg::*;

   localparam int GW = SAMPLE_W + GRAVITY_FRACTION_BITS;
   localparam int DW = GW + 1;
   localparam int PW = DW + WEIGHT_W;
   localparam int SH = GRAVITY_FRACTION_BITS - OUT_FRAC_BITS;

   logic signed [GW-1:0]        gravity_ff, gravity_in;
   logic signed [GW-1:0]        scaled_ff, scaled_in;
   logic signed [DW-1:0]        gap_ff, gap_in;
   logic signed [DW-1:0]        step, neg_step;
   logic signed [PW-1:0]        acc_ff, acc_in;
   logic signed [RES_W-1:0]     res_ff, res_in;
   logic signed [2*RES_W-1:0]   prod;
   square_type                  square_ff, square_in;

   always_comb begin
      scaled_in = {sample, {GRAVITY_FRACTION_BITS{1'b0}}};
      gap_in    = {gravity_ff[GW-1], gravity_ff} - {scaled_in[GW-1], scaled_in};
      if (ctl.load) begin
         acc_in = '0;
      end else if (ctl.mac) begin
         acc_in = (acc_ff <<< 1)
                + (ctl.wbit ? {{WEIGHT_W{gap_ff[DW-1]}}, gap_ff} : {PW{1'b0}});
      end else begin
         acc_in = acc_ff;
      end
      step     = $signed(acc_ff[PW-1:WEIGHT_W]);
      neg_step = -step;
      if (ctl.primed) begin
         gravity_in = scaled_ff + $signed(step[GW-1:0]);
         res_in     = $signed(neg_step[DW-1:SH]);
      end else begin
         gravity_in = scaled_ff;
         res_in     = '0;
      end
      prod      = res_ff * res_ff;
      square_in = prod[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= '0;
      end else if (ctl.update) begin
         gravity_ff <= gravity_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.load) begin
         scaled_ff <= scaled_in;
         gap_ff    <= gap_in;
      end
      if (ctl.update) begin
         res_ff <= res_in;
      end
      if (ctl.square) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

/* src/dvm_sqrt.sv */
// Merging stage: sum of the lane squares and a one-bit-per-cycle integer square root.
`timescale 1ns / 1ps

module dvm_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dvm_pkg::square_type sq_x,
   input  dvm_pkg::square_type sq_y,
   input  dvm_pkg::square_type sq_z,
   output logic                busy,
   output dvm_pkg::root_type   root
);
   import dvm_pkg::*;

   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] radicand_ff, radicand_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] rem_sh, trial;
   root_type         root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   always_comb begin
      sum    = {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
      rem_sh = {rem_ff[REM_W-3:0], radicand_ff[SUM_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      radicand_in = radicand_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      if (start) begin
         radicand_in = sum;
         rem_in      = '0;
         root_in     = '0;
         cnt_in      = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         radicand_in = {radicand_ff[SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

/* src/dynamic_vibration_magnitude.sv */
// Top level: configuration register, sequencer, three axis lanes, root stage and result register.
`timescale 1ns / 1ps

// Each accepted sample updates a per-axis gravity estimate and returns the length of the
// residual vector in counts with 8 fraction bits. From acceptance, the axis lanes run the
// bit-serial weight multiply, then update the estimate and square the residual, the sum of
// the squares goes to the square root, which resolves one result bit per cycle and then
// signals done, and the output register is loaded once any earlier result has been taken.
// A new sample can be accepted in the cycle after the result is loaded into the output
// register. The first sample after reset loads the estimate and yields zero.
module dynamic_vibration_magnitude #(
   parameter int GRAVITY_FRACTION_BITS = dvm_pkg::GRAVITY_FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dvm_pkg::sample_type             req_accel_x,
   input  dvm_pkg::sample_type             req_accel_y,
   input  dvm_pkg::sample_type             req_accel_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dvm_pkg::root_type               rsp_vibration_magnitude,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dvm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dvm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dvm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import dvm_pkg::*;

   localparam int MCNT_W = $clog2(WEIGHT_W);
   localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(WEIGHT_W - 1);

   state_type         state_ff, state_in;
   weight_type        weight_ff;
   weight_type        wsh_ff, wsh_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic              primed_ff;
   logic              rsp_valid_ff;
   root_type          rsp_data_ff;
   logic              accept, out_load, sqrt_start, sqrt_busy, csr_write;
   lane_ctl_type      ctl;
   square_type        sq_x, sq_y, sq_z;
   root_type          root;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_SMOOTHING_WEIGHT: csr_prdata = {{(CSR_DATA_W - WEIGHT_W){1'b0}}, weight_ff};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write && csr_paddr[CSR_ADDR_W-1] == REG_SMOOTHING_WEIGHT) begin
         weight_ff <= csr_pwdata[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MAC;
         ST_MAC:    if (mcnt_ff == MCNT_LAST) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_MERGE;
         ST_MERGE:  state_in = ST_ROOT;
         ST_ROOT:   if (!sqrt_busy) state_in = ST_OUT;
         ST_OUT:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      accept     = req_valid && req_ready;
      out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      sqrt_start = (state_ff == ST_MERGE);
      ctl.load   = accept;
      ctl.mac    = (state_ff == ST_MAC);
      ctl.wbit   = wsh_ff[WEIGHT_W-1];
      ctl.update = (state_ff == ST_UPDATE);
      ctl.primed = primed_ff;
      ctl.square = (state_ff == ST_SQUARE);
      wsh_in     = wsh_ff;
      mcnt_in    = mcnt_ff;
      if (accept) begin
         wsh_in  = weight_ff;
         mcnt_in = '0;
      end else if (ctl.mac) begin
         wsh_in  = {wsh_ff[WEIGHT_W-2:0], 1'b0};
         mcnt_in = mcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mcnt_ff      <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mcnt_ff  <= mcnt_in;
         if (ctl.update) begin
            primed_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wsh_ff <= wsh_in;
      if (out_load) begin
         rsp_data_ff <= root;
      end
   end

   dvm_lane #(.GRAVITY_FRACTION_BITS(GRAVITY_FRACTION_BITS)) u_lane_x (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(req_accel_x), .square(sq_x)
   );

   dvm_lane #(.GRAVITY_FRACTION_BITS(GRAVITY_FRACTION_BITS)) u_lane_y (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(req_accel_y), .square(sq_y)
   );

   dvm_lane #(.GRAVITY_FRACTION_BITS(GRAVITY_FRACTION_BITS)) u_lane_z (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(req_accel_z), .square(sq_z)
   );

   dvm_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .start(sqrt_start),
      .sq_x(sq_x),
      .sq_y(sq_y),
      .sq_z(sq_z),
      .busy(sqrt_busy),
      .root(root)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_vibration_magnitude = rsp_data_ff;

   a_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MAC)
      else $error("accepted beat did not start the multiply");

   a_merge_starts_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |=> sqrt_busy && state_ff == ST_ROOT)
      else $error("root stage did not start after the merge");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result beat was not presented");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      sqrt_busy |-> !req_ready)
      else $error("input taken while the root stage is busy");

endmodule
